@@ sv/bdt_pkg.sv @@
// Shared types and constants for the buffer dispatch and take block.
package bdt_pkg;

  localparam int SlotCount = 8;
  localparam int TypeW     = 3;
  localparam int LevelW    = 3;
  localparam int MaskW     = 8;
  localparam int NumberW   = 4;
  localparam int CfgW      = SlotCount * TypeW;
  localparam int DataW     = 32;
  localparam int AddrW     = 3;

  localparam logic [1:0] OpPutShortest = 2'd0;
  localparam logic [1:0] OpPutFirst    = 2'd1;
  localparam logic [1:0] OpTake        = 2'd2;

  localparam logic AddrQueueTypes = 1'b0;

  typedef struct packed {
    logic [1:0]       operation;
    logic [TypeW-1:0] part_type;
    logic [MaskW-1:0] take_mask;
  } bdt_req_t;

  typedef struct packed {
    logic [NumberW-1:0] queue_number;
    logic               take_granted;
  } bdt_rsp_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic apply;
  } bdt_cmd_t;

  typedef struct packed {
    logic scan_last;
  } bdt_status_t;

endpackage

@@ sv/bdt_cfg_regs.sv @@
// Configuration register file with an APB-style write and read port.
module bdt_cfg_regs import bdt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output logic [CfgW-1:0]  queue_types_o
);

  logic [CfgW-1:0] queue_types_q;
  logic            sel_types;

  assign pready    = 1'b1;
  assign sel_types = (paddr[AddrW-1] == AddrQueueTypes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_types_q <= '0;
    end else if (psel && penable && pwrite && pready && sel_types) begin
      queue_types_q <= pwdata[CfgW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_types) begin
      prdata = DataW'(queue_types_q);
    end
  end

  assign queue_types_o = queue_types_q;

endmodule

@@ sv/bdt_ctrl.sv @@
// Controller state machine that sequences capture, queue scan and update.
module bdt_ctrl import bdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  bdt_status_t status_i,
  output bdt_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan    = (state_q == ST_SCAN);
    cmd_o.apply   = (state_q == ST_APPLY) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.apply) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status_i.scan_last) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/bdt_datapath.sv @@
// Datapath with queue levels, the scan registers and the result register.
module bdt_datapath import bdt_pkg::*; #(
  parameter int NUM_QUEUES     = 8,
  parameter int QUEUE_CAPACITY = 4,
  parameter int MIN_LEVEL      = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bdt_cmd_t        cmd_i,
  output bdt_status_t     status_o,
  input  bdt_req_t        req_i,
  input  logic [CfgW-1:0] queue_types_i,
  output bdt_rsp_t        rsp_o
);

  localparam int IdxW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int ExtW  = (IdxW > 4) ? IdxW : 4;
  localparam int XMskW = (NUM_QUEUES > MaskW) ? NUM_QUEUES : MaskW;

  logic [LevelW-1:0]  levels_q [NUM_QUEUES];
  logic [LevelW-1:0]  levels_d [NUM_QUEUES];
  bdt_req_t           req_q;
  logic [IdxW-1:0]    idx_q;
  logic [NumberW-1:0] chosen_q;
  logic [LevelW-1:0]  best_q;
  logic               ok_q;
  bdt_rsp_t           rsp_q;

  logic [ExtW-1:0]    idx_ext;
  logic [2:0]         slot;
  logic               in_slot;
  logic [TypeW-1:0]   slot_type;
  logic [LevelW-1:0]  level;
  logic               is_put;
  logic               is_take;
  logic               shortest;
  logic               candidate;
  logic               take_pick;
  logic [XMskW-1:0]   mask_ext;

  assign is_put   = (req_q.operation == OpPutShortest) || (req_q.operation == OpPutFirst);
  assign is_take  = (req_q.operation == OpTake);
  assign shortest = (req_q.operation == OpPutShortest);
  assign mask_ext = XMskW'(req_q.take_mask);

  assign idx_ext   = ExtW'(idx_q);
  assign slot      = idx_ext[2:0];
  assign in_slot   = (idx_ext < ExtW'(SlotCount));
  assign slot_type = queue_types_i[TypeW*slot +: TypeW];
  assign level     = levels_q[idx_q];

  assign candidate = in_slot && (slot_type == req_q.part_type)
                     && (level < LevelW'(QUEUE_CAPACITY));
  assign take_pick = shortest ? (level < best_q) : (chosen_q == '0);

  assign status_o.scan_last = (idx_q == IdxW'(NUM_QUEUES - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= req_i;
      idx_q    <= '0;
      chosen_q <= '0;
      best_q   <= LevelW'(QUEUE_CAPACITY);
      ok_q     <= 1'b1;
    end else if (cmd_i.scan) begin
      if (!status_o.scan_last) begin
        idx_q <= idx_q + 1'b1;
      end
      if (candidate && take_pick) begin
        chosen_q <= {1'b0, slot} + NumberW'(1);
        best_q   <= level;
      end
      if (in_slot && req_q.take_mask[slot] && (level <= LevelW'(MIN_LEVEL))) begin
        ok_q <= 1'b0;
      end
    end
    if (cmd_i.apply) begin
      rsp_q.queue_number <= is_put ? chosen_q : '0;
      rsp_q.take_granted <= is_take && ok_q;
    end
  end

  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      levels_d[q] = levels_q[q];
      if (is_put && (chosen_q != '0) && (chosen_q == NumberW'(q + 1))) begin
        levels_d[q] = levels_q[q] + 1'b1;
      end else if (is_take && ok_q && mask_ext[q]) begin
        levels_d[q] = levels_q[q] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        levels_q[q] <= '0;
      end
    end else if (cmd_i.apply) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        levels_q[q] <= levels_d[q];
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

@@ sv/buffer_dispatch_and_take.sv @@
// Top level of the buffer dispatch and take block.
// Each request passes through a capture step, a scan that reads one queue level a cycle from
// the level registers, queue by queue, and an update step that updates the levels and loads
// the result register. No new request is taken until the previous one is updated. The update
// waits while a previous result is still stalled at the output. Queue levels clear at reset,
// so requests are taken right away.
module buffer_dispatch_and_take import bdt_pkg::*; #(
  parameter int NUM_QUEUES     = 8,
  parameter int QUEUE_CAPACITY = 4,
  parameter int MIN_LEVEL      = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bdt_req_t         in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bdt_rsp_t         out_rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  bdt_cmd_t        cmd;
  bdt_status_t     status;
  logic [CfgW-1:0] queue_types;

  bdt_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .queue_types_o (queue_types)
  );

  bdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bdt_datapath #(
    .NUM_QUEUES     (NUM_QUEUES),
    .QUEUE_CAPACITY (QUEUE_CAPACITY),
    .MIN_LEVEL      (MIN_LEVEL)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .req_i         (in_req_i),
    .queue_types_i (queue_types),
    .rsp_o         (out_rsp_o)
  );

endmodule

@@ sv/bdt_checker.sv @@
// Port-level checker for the buffer dispatch and take block and its bind.
module bdt_checker import bdt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input bdt_rsp_t out_rsp_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted back to back");

  // A granted take never names a queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.take_granted |-> out_rsp_o.queue_number == '0)
    else $error("granted take carries a queue number");

  // Only the eight typed queues can be chosen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.queue_number <= NumberW'(SlotCount))
    else $error("queue number out of range");

endmodule

bind buffer_dispatch_and_take bdt_checker u_bdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
